@@ hdl/aho_pkg.sv @@
package aho_pkg;

  localparam int PHASE_BITS          = 24;
  localparam int COUNT_BITS          = 24;
  localparam int AMP_BITS            = 16;
  localparam int HCOUNT_BITS         = 4;
  localparam int SAMPLE_W            = 20;
  localparam int SINE_W              = 15;
  localparam int RECIP_W             = 16;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 24;

  localparam int MAX_HARMONICS_DEF   = 16;
  localparam int SINE_ADDR_BITS_DEF  = 10;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC    = 3'd0,
    CFG_START_PHASE  = 3'd1,
    CFG_AMPLITUDE    = 3'd2,
    CFG_HCOUNT       = 3'd3,
    CFG_WAVEFORM     = 3'd4,
    CFG_SAMPLE_COUNT = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PUBLISH
  } aho_state_t;

  typedef struct packed {
    logic start;    // request accepted: clear accumulator, reload on restart
    logic issue;    // push the current slot into the term pipeline
    logic publish;  // load the result register and step the run counter
  } aho_cmd_t;

  typedef struct packed {
    logic busy;     // terms still in flight
  } aho_status_t;

  // Bit-by-bit restoring division, only ever evaluated at elaboration.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q0.16 reciprocal of h, rounded, saturated so that h = 1 gives all ones.
  function automatic logic [RECIP_W-1:0] recip_q16(int unsigned h);
    logic [63:0] q;
    q = udiv64(64'd65536 + 64'(h >> 1), 64'(h));
    return (q > 64'd65535) ? RECIP_W'(65535) : q[RECIP_W-1:0];
  endfunction

  // Quarter-wave sine entry, Q2.30 Taylor series rounded to Q0.15.
  function automatic logic [SINE_W-1:0] sine_entry(int unsigned i, int unsigned abits);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    x    = (HALF_PI_Q30 * (64'(i) * 64'd2 + 64'd1)) >> (abits + 1);
    sum  = x;
    term = x;
    for (int k = 1; k <= 8; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = udiv64(term, 64'((2 * k) * (2 * k + 1)));
      if (k % 2 == 1) begin
        sum = (term > sum) ? 64'd0 : sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    v = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    return (v > 64'd32767) ? SINE_W'(32767) : v[SINE_W-1:0];
  endfunction

endpackage

@@ hdl/aho_in_if.sv @@
interface aho_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

@@ hdl/aho_out_if.sv @@
interface aho_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [aho_pkg::SAMPLE_W-1:0]   sample;
  logic        [aho_pkg::COUNT_BITS-1:0] sample_index;
  logic                                  last;

  modport source (output valid, output sample, output sample_index, output last,
                  input ready);
  modport sink   (input valid, input sample, input sample_index, input last,
                  output ready);
endinterface

@@ hdl/aho_sine_rom.sv @@
module aho_sine_rom #(
  parameter int ADDR_BITS = aho_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic [ADDR_BITS-1:0]        addr,
  output logic [aho_pkg::SINE_W-1:0]  data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  typedef logic [aho_pkg::SINE_W-1:0] sine_tab_t [DEPTH];

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int i = 0; i < DEPTH; i++) begin
      t[i] = aho_pkg::sine_entry(i, ADDR_BITS);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  logic [aho_pkg::SINE_W-1:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= SINE_TAB[addr];
  end

  assign data = data_r;

endmodule

@@ hdl/aho_datapath.sv @@
module aho_datapath #(
  parameter int MAX_HARMONICS  = aho_pkg::MAX_HARMONICS_DEF,
  parameter int SINE_ADDR_BITS = aho_pkg::SINE_ADDR_BITS_DEF,
  parameter int SLOT_BITS      = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [aho_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aho_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_restart,
  input  aho_pkg::aho_cmd_t                    cmd,
  input  logic [SLOT_BITS-1:0]                 slot,
  output aho_pkg::aho_status_t                 status,
  output logic signed [aho_pkg::SAMPLE_W-1:0]  out_sample,
  output logic [aho_pkg::COUNT_BITS-1:0]       out_sample_index,
  output logic                                 out_last
);

  localparam int PB     = aho_pkg::PHASE_BITS;
  localparam int CB     = aho_pkg::COUNT_BITS;
  localparam int AB     = aho_pkg::AMP_BITS;
  localparam int SW     = aho_pkg::SINE_W;
  localparam int RW     = aho_pkg::RECIP_W;
  localparam int OW     = aho_pkg::SAMPLE_W;
  localparam int HW     = SLOT_BITS + 1;
  localparam int ACC_W  = SLOT_BITS + 21;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  typedef logic [RW-1:0] recip_tab_t [1 << HW];

  function automatic recip_tab_t build_recip();
    recip_tab_t t;
    for (int i = 0; i < (1 << HW); i++) begin
      t[i] = aho_pkg::recip_q16(i);
    end
    return t;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

  // configuration
  logic [PB-1:0]                    phase_inc_r;
  logic [PB-1:0]                    start_phase_r;
  logic [AB-1:0]                    amplitude_r;
  logic [aho_pkg::HCOUNT_BITS-1:0]  hcount_r;
  logic                             waveform_r;
  logic [CB-1:0]                    sample_count_r;

  // oscillator state
  logic [PB-1:0]  phase_r [MAX_HARMONICS];
  logic [CB-1:0]  cnt_r;

  // term pipeline
  logic                     v1_r, v2_r, v3_r, v4_r;
  logic                     neg1_r, neg2_r, neg3_r, neg4_r;
  logic [RW-1:0]            recip_r;
  logic [AB+RW-1:0]         prod_a_r;
  logic [SW-1:0]            sin2_r, sin3_r;
  logic [AB-1:0]            ah_r;
  logic [SW+AB-1:0]         mprod_r;
  logic signed [ACC_W-1:0]  acc_r;

  // result register
  logic signed [OW-1:0]     sample_r;
  logic [CB-1:0]            index_r;
  logic                     last_r;

  logic [HW-1:0]            h_cur;
  logic [PB-1:0]            ph_cur;
  logic [PB+HW-1:0]         step_full;
  logic [1:0]               quad;
  logic [SINE_ADDR_BITS-1:0] rom_addr;
  logic [SW-1:0]            rom_data;
  logic                     term_en;
  logic [AB+RW:0]           ah_round;
  logic [SW+AB:0]           mag_round;
  logic signed [ACC_W-1:0]  term_w;
  logic [CB:0]              run_len;
  logic                     last_w;
  logic                     reload_w;
  logic signed [OW-1:0]     sat_w;

  assign h_cur     = waveform_r ? {slot, 1'b1} : ({1'b0, slot} + HW'(1));
  assign ph_cur    = phase_r[slot];
  assign step_full = {{PB{1'b0}}, h_cur} * {{HW{1'b0}}, phase_inc_r};
  assign term_en   = (32'(slot) <= 32'(hcount_r));

  // top two bits pick the quadrant; odd quadrants walk the table backwards
  assign quad     = ph_cur[PB-1 -: 2];
  assign rom_addr = quad[0] ? ~ph_cur[PB-3 -: SINE_ADDR_BITS] : ph_cur[PB-3 -: SINE_ADDR_BITS];

  aho_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign ah_round  = {1'b0, prod_a_r} + (AB+RW+1)'(32768);
  assign mag_round = {1'b0, mprod_r} + (SW+AB+1)'(32768);
  assign term_w    = neg4_r ? -ACC_W'(mag_round[SW+AB:16]) : ACC_W'(mag_round[SW+AB:16]);

  // a count of zero stands for the full counter range
  assign run_len  = (sample_count_r == '0) ? ((CB+1)'(1) << CB) : {1'b0, sample_count_r};
  assign last_w   = ({1'b0, cnt_r} + (CB+1)'(1)) >= run_len;
  assign reload_w = (cmd.start && in_restart) || (cmd.publish && last_w);

  always_comb begin
    if (acc_r > SAT_HI) begin
      sat_w = SAT_HI[OW-1:0];
    end else if (acc_r < SAT_LO) begin
      sat_w = SAT_LO[OW-1:0];
    end else begin
      sat_w = acc_r[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r    <= '0;
      start_phase_r  <= '0;
      amplitude_r    <= '0;
      hcount_r       <= '0;
      waveform_r     <= 1'b0;
      sample_count_r <= CB'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        aho_pkg::CFG_PHASE_INC:    phase_inc_r    <= cfg_data[PB-1:0];
        aho_pkg::CFG_START_PHASE:  start_phase_r  <= cfg_data[PB-1:0];
        aho_pkg::CFG_AMPLITUDE:    amplitude_r    <= cfg_data[AB-1:0];
        aho_pkg::CFG_HCOUNT:       hcount_r       <= cfg_data[aho_pkg::HCOUNT_BITS-1:0];
        aho_pkg::CFG_WAVEFORM:     waveform_r     <= cfg_data[0];
        aho_pkg::CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_HARMONICS; i++) begin
        phase_r[i] <= '0;
      end
      cnt_r <= '0;
    end else begin
      if (reload_w) begin
        for (int i = 0; i < MAX_HARMONICS; i++) begin
          phase_r[i] <= start_phase_r;
        end
      end else if (cmd.issue) begin
        phase_r[slot] <= ph_cur + step_full[PB-1:0];
      end
      if (reload_w) begin
        cnt_r <= '0;
      end else if (cmd.publish) begin
        cnt_r <= cnt_r + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue && term_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    recip_r  <= RECIP_TAB[h_cur];
    neg1_r   <= quad[1];
    prod_a_r <= amplitude_r * recip_r;
    sin2_r   <= rom_data;
    neg2_r   <= neg1_r;
    // rounded product stays below 2^32, so the carry bit is never set
    ah_r     <= ah_round[AB+RW-1:16];
    sin3_r   <= sin2_r;
    neg3_r   <= neg2_r;
    mprod_r  <= sin3_r * ah_r;
    neg4_r   <= neg3_r;
    if (cmd.start) begin
      acc_r <= '0;
    end else if (v4_r) begin
      acc_r <= acc_r + term_w;
    end
    if (cmd.publish) begin
      sample_r <= sat_w;
      index_r  <= cnt_r;
      last_r   <= last_w;
    end
  end

  assign status.busy      = v1_r | v2_r | v3_r | v4_r;
  assign out_sample       = sample_r;
  assign out_sample_index = index_r;
  assign out_last         = last_r;

endmodule

@@ hdl/aho_ctrl.sv @@
module aho_ctrl #(
  parameter int MAX_HARMONICS = aho_pkg::MAX_HARMONICS_DEF,
  parameter int SLOT_BITS     = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  aho_pkg::aho_status_t  status,
  output aho_pkg::aho_cmd_t     cmd,
  output logic [SLOT_BITS-1:0]  slot
);

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(MAX_HARMONICS - 1);

  aho_pkg::aho_state_t   state_r, state_nxt;
  logic [SLOT_BITS-1:0]  slot_r, slot_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aho_pkg::ST_IDLE;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      aho_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          slot_nxt  = '0;
          state_nxt = aho_pkg::ST_RUN;
        end
      end
      aho_pkg::ST_RUN: begin
        // every slot advances its phase, summed or not
        cmd.issue = 1'b1;
        if (slot_r == LAST_SLOT) begin
          state_nxt = aho_pkg::ST_DRAIN;
        end else begin
          slot_nxt = slot_r + SLOT_BITS'(1);
        end
      end
      aho_pkg::ST_DRAIN: begin
        if (!status.busy) begin
          state_nxt = aho_pkg::ST_PUBLISH;
        end
      end
      aho_pkg::ST_PUBLISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = aho_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = aho_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign slot      = slot_r;

endmodule

@@ hdl/additive_harmonic_oscillator_top.sv @@
// Additive harmonic oscillator: each request on in_ch yields one summed sample on out_ch.
// The sample is the sum of up to harmonic_count+1 sine terms scaled by amplitude/h, with
// all harmonics (waveform 0) or odd harmonics only (waveform 1); every slot keeps its own
// phase accumulator. Before a request's result loads, the harmonic slots pass one per cycle
// through a single sine ROM port and a two-multiplier term pipeline, which is then drained;
// the drain is longest when the top slots are summed, and the load waits while the previous
// result still sits unaccepted on out_ch. A new request is taken while the previous result
// still waits on out_ch. The user must write registers through cfg_* only between requests;
// the block leaves this check to the user. start_phase takes effect at the next restart or
// run end.
module additive_harmonic_oscillator_top #(
  parameter int MAX_HARMONICS  = aho_pkg::MAX_HARMONICS_DEF,
  parameter int SINE_ADDR_BITS = aho_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  aho_in_if.sink                          in_ch,
  aho_out_if.source                       out_ch,
  input  logic                            cfg_wr_en,
  input  logic [aho_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aho_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOT_BITS = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;

  aho_pkg::aho_cmd_t     cmd;
  aho_pkg::aho_status_t  status;
  logic [SLOT_BITS-1:0]  slot;

  aho_ctrl #(
    .MAX_HARMONICS (MAX_HARMONICS),
    .SLOT_BITS     (SLOT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd),
    .slot      (slot)
  );

  aho_datapath #(
    .MAX_HARMONICS  (MAX_HARMONICS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SLOT_BITS      (SLOT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_restart       (in_ch.restart),
    .cmd              (cmd),
    .slot             (slot),
    .status           (status),
    .out_sample       (out_ch.sample),
    .out_sample_index (out_ch.sample_index),
    .out_last         (out_ch.last)
  );

endmodule
